// File: hdl/assert_macros.svh
// assertion macros for the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent at the same clock edge
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: hdl/fbpa_pkg.sv
// types and constants of the block pool allocator
`default_nettype none

package fbpa_pkg;

	// free list and flag memory geometry
	localparam int RING_DEPTH = 4096;
	localparam int RING_AW    = 12;
	localparam int CNT_W      = 13;
	localparam int SIZE_W     = 16;
	localparam int FAIL_W     = 32;
	localparam int SEG_W      = 3;

	// input stream layout
	localparam int IN_W = 32;
	localparam int OUT_W = 120;

	// front queue depth
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SEGS = 1'b1;

	localparam logic [SIZE_W-1:0] BLOCK_SIZE_RESET = 16'd4;

	// request modes
	localparam logic [1:0] MODE_ALLOC = 2'd0;
	localparam logic [1:0] MODE_FREE  = 2'd1;
	localparam logic [1:0] MODE_GROW  = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	// result status codes
	localparam logic [2:0] STAT_OK           = 3'd0;
	localparam logic [2:0] STAT_TOO_LARGE    = 3'd1;
	localparam logic [2:0] STAT_EMPTY        = 3'd2;
	localparam logic [2:0] STAT_ALREADY_FREE = 3'd3;
	localparam logic [2:0] STAT_BAD_INDEX    = 3'd4;

	// operation after classification by the front
	typedef enum logic [2:0] {
		OP_ALLOC,
		OP_TOO_BIG,
		OP_FREE,
		OP_GROW,
		OP_NOP
	} fbpa_op_t;

	// one queued request
	typedef struct packed {
		fbpa_op_t           op;
		logic [SIZE_W-1:0]  req;
		logic [RING_AW-1:0] idx;
	} fbpa_item_t;

	// back engine states
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_EXEC,
		BK_GROW
	} fbpa_state_t;

	// result beat, last field in the lowest bits
	typedef struct packed {
		logic [3:0]         pad;
		logic [FAIL_W-1:0]  failure_total;
		logic [SIZE_W-1:0]  largest_request;
		logic [CNT_W-1:0]   peak_in_use;
		logic [CNT_W-1:0]   total_count;
		logic [CNT_W-1:0]   free_count;
		logic [CNT_W-1:0]   in_use_count;
		logic [2:0]         status;
		logic [RING_AW-1:0] granted_index;
		logic               granted;
	} fbpa_result_t;

endpackage

`default_nettype wire

// File: hdl/fbpa_front.sv
// front: accepts request beats, classifies them and queues them for the back
`default_nettype none

module fbpa_front
	import fbpa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	// mode[1:0], request_size[17:2], block_index[29:18], zero [31:30]
	input  wire logic [IN_W-1:0]   s_axis_tdata,
	input  wire logic [SIZE_W-1:0] block_size,
	output logic                   item_valid,
	input  wire logic              item_ready,
	output fbpa_item_t             item
);

	logic [1:0]         mode;
	logic [SIZE_W-1:0]  req;
	logic [RING_AW-1:0] idx;
	fbpa_item_t         cls;
	fbpa_item_t         queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               push;
	logic               pop;

	// unpack the beat
	assign mode = s_axis_tdata[1:0];
	assign req  = s_axis_tdata[17:2];
	assign idx  = s_axis_tdata[29:18];

	// classify by mode, size check against the block size
	always_comb begin
		cls.req = req;
		cls.idx = idx;
		unique case (mode)
			MODE_ALLOC: cls.op = (req > block_size) ? OP_TOO_BIG : OP_ALLOC;
			MODE_FREE:  cls.op = OP_FREE;
			MODE_GROW:  cls.op = OP_GROW;
			MODE_NONE:  cls.op = OP_NOP;
		endcase
	end

	// queue handshakes
	assign s_axis_tready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign item_valid    = (count_q != '0);
	assign push          = s_axis_tvalid && s_axis_tready;
	assign pop           = item_valid && item_ready;
	assign item          = queue_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/fbpa_back.sv
// back: free list ring, free flags, counters and the result register
`default_nettype none

module fbpa_back
	import fbpa_pkg::*;
#(
	parameter int BLOCKS_PER_SEGMENT = 1024,
	parameter int MAX_SEGMENTS       = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire fbpa_item_t       item,
	input  wire logic [SEG_W-1:0] target_segments,
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic [OUT_W-1:0]      m_axis_tdata
);

	localparam int FIT_SEGS = RING_DEPTH / BLOCKS_PER_SEGMENT;
	localparam int SEG_CAP  = (MAX_SEGMENTS < FIT_SEGS) ? MAX_SEGMENTS : FIT_SEGS;

	fbpa_state_t        state_q, state_d;
	fbpa_item_t         cur_q;
	logic [RING_AW-1:0] head_q, head_d;
	logic [RING_AW-1:0] tail_q, tail_d;
	logic [CNT_W-1:0]   free_q, free_d;
	logic [CNT_W-1:0]   inuse_q, inuse_d;
	logic [CNT_W-1:0]   total_q, total_d;
	logic [CNT_W-1:0]   peak_q, peak_d;
	logic [SIZE_W-1:0]  largest_q, largest_d;
	logic [FAIL_W-1:0]  fail_q, fail_d;

	logic [RING_AW-1:0] ring_mem [RING_DEPTH];
	logic               mark_mem [RING_DEPTH];
	logic [RING_AW-1:0] ring_rd_q;
	logic               mark_rd_q;
	logic               rd_en;
	logic               ring_we;
	logic [RING_AW-1:0] ring_waddr;
	logic [RING_AW-1:0] ring_wdata;
	logic               mark_we;
	logic [RING_AW-1:0] mark_waddr;
	logic               mark_wdata;

	logic [4:0]         want_segs;
	logic [CNT_W-1:0]   want_total;
	logic               out_free;
	logic               load_out;
	logic               out_valid_q;
	fbpa_result_t       out_q;
	fbpa_result_t       res;

	// grow target in blocks, capped by the segment limit and by what the ring holds
	assign want_segs  = (5'(target_segments) > 5'(SEG_CAP)) ? 5'(SEG_CAP)
		: 5'(target_segments);
	assign want_total = CNT_W'(32'(want_segs) * 32'(BLOCKS_PER_SEGMENT));

	assign out_free = !out_valid_q || m_axis_tready;

	// next state, counter updates and memory strobes
	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		rd_en      = 1'b0;
		head_d     = head_q;
		tail_d     = tail_q;
		free_d     = free_q;
		inuse_d    = inuse_q;
		total_d    = total_q;
		peak_d     = peak_q;
		largest_d  = largest_q;
		fail_d     = fail_q;
		ring_we    = 1'b0;
		ring_waddr = tail_q;
		ring_wdata = cur_q.idx;
		mark_we    = 1'b0;
		mark_waddr = cur_q.idx;
		mark_wdata = 1'b1;
		load_out   = 1'b0;
		res        = '0;

		unique case (state_q)
			BK_IDLE: begin
				// take the next request, read ring head and the flag of the request's index
				if (item_valid) begin
					item_ready = 1'b1;
					rd_en      = 1'b1;
					state_d    = (item.op == OP_GROW) ? BK_GROW : BK_EXEC;
				end
			end
			BK_EXEC: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
					unique case (cur_q.op)
						OP_ALLOC: begin
							if (cur_q.req > largest_q) begin
								largest_d = cur_q.req;
							end
							if (free_q == '0) begin
								if (fail_q != '1) begin
									fail_d = fail_q + 1'b1;
								end
								res.status = STAT_EMPTY;
							end else begin
								res.granted       = 1'b1;
								res.granted_index = ring_rd_q;
								head_d            = head_q + 1'b1;
								free_d            = free_q - 1'b1;
								mark_we           = 1'b1;
								mark_waddr        = ring_rd_q;
								mark_wdata        = 1'b0;
								inuse_d           = inuse_q + 1'b1;
								if (inuse_d > peak_q) begin
									peak_d = inuse_d;
								end
							end
						end
						OP_FREE: begin
							if ({1'b0, cur_q.idx} >= total_q) begin
								res.status = STAT_BAD_INDEX;
							end else if (mark_rd_q) begin
								res.status = STAT_ALREADY_FREE;
							end else begin
								ring_we = 1'b1;
								tail_d  = tail_q + 1'b1;
								mark_we = 1'b1;
								free_d  = free_q + 1'b1;
								if (inuse_q != '0) begin
									inuse_d = inuse_q - 1'b1;
								end
							end
						end
						OP_TOO_BIG: res.status = STAT_TOO_LARGE;
						default: ;
					endcase
				end
			end
			BK_GROW: begin
				// one new block per cycle until the target is reached
				if (total_q < want_total) begin
					ring_we    = 1'b1;
					ring_wdata = total_q[RING_AW-1:0];
					mark_we    = 1'b1;
					mark_waddr = total_q[RING_AW-1:0];
					tail_d     = tail_q + 1'b1;
					free_d     = free_q + 1'b1;
					total_d    = total_q + 1'b1;
				end else if (out_free) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase

		res.in_use_count    = inuse_d;
		res.free_count      = free_d;
		res.total_count     = total_d;
		res.peak_in_use     = peak_d;
		res.largest_request = largest_d;
		res.failure_total   = fail_d;
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			head_q    <= '0;
			tail_q    <= '0;
			free_q    <= '0;
			inuse_q   <= '0;
			total_q   <= '0;
			peak_q    <= '0;
			largest_q <= '0;
			fail_q    <= '0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			free_q    <= free_d;
			inuse_q   <= inuse_d;
			total_q   <= total_d;
			peak_q    <= peak_d;
			largest_q <= largest_d;
			fail_q    <= fail_d;
		end
	end

	// request being worked on
	always_ff @(posedge clk) begin
		if (item_ready) begin
			cur_q <= item;
		end
	end

	// free list ring, read data registered
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_waddr] <= ring_wdata;
		end
		if (rd_en) begin
			ring_rd_q <= ring_mem[head_q];
		end
	end

	// free flags, read for any index but only used below the block total
	always_ff @(posedge clk) begin
		if (mark_we) begin
			mark_mem[mark_waddr] <= mark_wdata;
		end
		if (rd_en) begin
			mark_rd_q <= mark_mem[item.idx];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

// File: hdl/fixed_block_pool_allocator_top.sv
// top level of the fixed block pool allocator
// Fixed-size block allocator with a first-in first-out free list of up to 4096
// block indices. Each request beat is classified and placed in a two-entry
// queue, so the input keeps taking beats while the queue has room, also while
// the engine works or a result waits. Allocate, free, mode 3 and oversized
// requests pass the engine's read state, for the registered read of the ring
// head and the free flag, and then its commit state, which waits for a free
// result register. Grow writes the new blocks one after another, each one
// write to the ring and to the flag memory, then commits its result. Exactly
// one result beat follows every request beat, in order. No clearing pass is
// needed after reset: flags and ring entries are only used below the grown total.
`default_nettype none

`include "assert_macros.svh"

module fixed_block_pool_allocator_top
	import fbpa_pkg::*;
#(
	parameter int BLOCKS_PER_SEGMENT = 1024,
	parameter int MAX_SEGMENTS       = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SIZE_W-1:0]    cfg_wdata,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	// mode[1:0], request_size[17:2], block_index[29:18], zero [31:30]
	input  wire logic [IN_W-1:0]      s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// granted[0], granted_index[12:1], status[15:13], in_use_count[28:16],
	// free_count[41:29], total_count[54:42], peak_in_use[67:55],
	// largest_request[83:68], failure_total[115:84], zero [119:116]
	output logic [OUT_W-1:0]          m_axis_tdata
);

	logic [SIZE_W-1:0] block_size_q;
	logic [SEG_W-1:0]  target_q;
	logic              item_valid;
	logic              item_ready;
	fbpa_item_t        item;
	fbpa_result_t      res_view;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= BLOCK_SIZE_RESET;
			target_q     <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_BLOCK_SIZE:  block_size_q <= cfg_wdata;
				CFG_TARGET_SEGS: target_q     <= cfg_wdata[SEG_W-1:0];
			endcase
		end
	end

	// accept and classify
	fbpa_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.block_size    (block_size_q),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.item          (item)
	);

	// carry out requests
	fbpa_back #(
		.BLOCKS_PER_SEGMENT (BLOCKS_PER_SEGMENT),
		.MAX_SEGMENTS       (MAX_SEGMENTS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_ready      (item_ready),
		.item            (item),
		.target_segments (target_q),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata)
	);

	// result fields for the checks below
	assign res_view = fbpa_result_t'(m_axis_tdata);

	// every created block is either on the free list or handed out
	`ASSERT_IMPLY(a_count_balance, clk, arst_n, m_axis_tvalid, (14'(res_view.free_count) + 14'(res_view.in_use_count)) == 14'(res_view.total_count), "free plus in-use differs from total")

	`ASSERT_IMPLY(a_peak_covers, clk, arst_n, m_axis_tvalid, res_view.peak_in_use >= res_view.in_use_count, "peak below in-use count")

	// a grant is an ok status with an index inside the pool
	`ASSERT_IMPLY(a_grant_ok, clk, arst_n, m_axis_tvalid && res_view.granted, (res_view.status == STAT_OK) && (13'(res_view.granted_index) < res_view.total_count), "bad grant")

	`ASSERT_IMPLY(a_no_grant_zero, clk, arst_n, m_axis_tvalid && !res_view.granted, res_view.granted_index == '0, "index set without grant")

endmodule

`default_nettype wire

// File: verif/fixed_block_pool_allocator_top_tb.sv
// self-checking testbench for the fixed block pool allocator top level
module fixed_block_pool_allocator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fbpa_pkg::*;

	localparam int BLOCKS_PER_SEG = 1024;
	localparam int SEG_LIMIT      = 4;
	localparam int LEG_ITEMS      = 125;
	localparam int LEG_COUNT      = 6;
	localparam int STALL_LIMIT    = 20000;
	localparam int REPORT_LIMIT   = 10;
	localparam int PLAN_LEN       = 23;

	// segment goal written before each random leg
	localparam int LEG_GOAL [LEG_COUNT] = '{2, 1, 3, 4, 3, 0};

	typedef enum logic {ROW_REQ, ROW_REG} row_kind_t;

	// one directed row; a register row carries the index in idx and the value in req
	typedef struct packed {
		row_kind_t          kind;
		logic [1:0]         mode;
		logic [SIZE_W-1:0]  req;
		logic [RING_AW-1:0] idx;
		logic               typed;
		logic               granted;
		logic [RING_AW-1:0] gidx;
		logic [2:0]         status;
	} plan_row_t;

	const plan_row_t plan [PLAN_LEN] = '{
		// empty pool, too large requests, bad index, grow and no-op with nothing grown
		'{ROW_REQ, MODE_ALLOC, 16'd0,     12'd0,    1'b1, 1'b0, 12'd0, STAT_EMPTY},
		'{ROW_REQ, MODE_ALLOC, 16'd4,     12'd0,    1'b1, 1'b0, 12'd0, STAT_EMPTY},
		'{ROW_REQ, MODE_ALLOC, 16'd5,     12'd0,    1'b1, 1'b0, 12'd0, STAT_TOO_LARGE},
		'{ROW_REQ, MODE_ALLOC, 16'hffff,  12'hfff,  1'b1, 1'b0, 12'd0, STAT_TOO_LARGE},
		'{ROW_REQ, MODE_FREE,  16'd0,     12'd0,    1'b1, 1'b0, 12'd0, STAT_BAD_INDEX},
		'{ROW_REQ, MODE_FREE,  16'hffff,  12'hfff,  1'b1, 1'b0, 12'd0, STAT_BAD_INDEX},
		'{ROW_REQ, MODE_GROW,  16'd0,     12'd0,    1'b1, 1'b0, 12'd0, STAT_OK},
		'{ROW_REQ, MODE_NONE,  16'hffff,  12'hfff,  1'b1, 1'b0, 12'd0, STAT_OK},
		'{ROW_REG, MODE_NONE,  16'd65532, 12'(CFG_BLOCK_SIZE),  1'b0, 1'b0, 12'd0, STAT_OK},
		'{ROW_REG, MODE_NONE,  16'd1,     12'(CFG_TARGET_SEGS), 1'b0, 1'b0, 12'd0, STAT_OK},
		// first segment, then allocate and free at the edges
		'{ROW_REQ, MODE_GROW,  16'd0,     12'd0,    1'b1, 1'b0, 12'd0, STAT_OK},
		'{ROW_REQ, MODE_ALLOC, 16'd65532, 12'd0,    1'b1, 1'b1, 12'd0, STAT_OK},
		'{ROW_REQ, MODE_ALLOC, 16'd65533, 12'd0,    1'b1, 1'b0, 12'd0, STAT_TOO_LARGE},
		'{ROW_REQ, MODE_ALLOC, 16'd0,     12'd0,    1'b1, 1'b1, 12'd1, STAT_OK},
		'{ROW_REQ, MODE_FREE,  16'd0,     12'd0,    1'b1, 1'b0, 12'd0, STAT_OK},
		'{ROW_REQ, MODE_FREE,  16'd0,     12'd0,    1'b1, 1'b0, 12'd0, STAT_ALREADY_FREE},
		'{ROW_REQ, MODE_FREE,  16'd0,     12'd1023, 1'b1, 1'b0, 12'd0, STAT_ALREADY_FREE},
		'{ROW_REQ, MODE_FREE,  16'd0,     12'd1024, 1'b1, 1'b0, 12'd0, STAT_BAD_INDEX},
		'{ROW_REQ, MODE_GROW,  16'd0,     12'd0,    1'b1, 1'b0, 12'd0, STAT_OK},
		'{ROW_REG, MODE_NONE,  16'd0,     12'(CFG_TARGET_SEGS), 1'b0, 1'b0, 12'd0, STAT_OK},
		// a lower target never shrinks the pool
		'{ROW_REQ, MODE_GROW,  16'd0,     12'd0,    1'b1, 1'b0, 12'd0, STAT_OK},
		'{ROW_REQ, MODE_ALLOC, 16'd1,     12'd0,    1'b0, 1'b0, 12'd0, STAT_OK},
		'{ROW_REQ, MODE_FREE,  16'd0,     12'd1,    1'b0, 1'b0, 12'd0, STAT_OK}
	};

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_wr_en     = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [SIZE_W-1:0]    cfg_wdata     = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	// mode[1:0], request_size[17:2], block_index[29:18], zero [31:30]
	logic [IN_W-1:0]      s_axis_tdata  = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	// granted[0], granted_index[12:1], status[15:13], in_use_count[28:16],
	// free_count[41:29], total_count[54:42], peak_in_use[67:55],
	// largest_request[83:68], failure_total[115:84], zero [119:116]
	logic [OUT_W-1:0]     m_axis_tdata;

	fixed_block_pool_allocator_top #(
		.BLOCKS_PER_SEGMENT(BLOCKS_PER_SEG),
		.MAX_SEGMENTS(SEG_LIMIT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// pool shadow: free list ring, free flags, counters and registers
	logic [RING_AW-1:0] ring_q [RING_DEPTH];
	bit                 flag_free [RING_DEPTH];
	logic [RING_AW-1:0] head_q     = '0;
	logic [RING_AW-1:0] tail_q     = '0;
	int unsigned        free_n     = 0;
	int unsigned        used_n     = 0;
	int unsigned        segs_n     = 0;
	int unsigned        peak_n     = 0;
	logic [SIZE_W-1:0]  largest_n  = '0;
	logic [FAIL_W-1:0]  fail_n     = '0;
	logic [SIZE_W-1:0]  size_limit = BLOCK_SIZE_RESET;
	int unsigned        seg_goal   = 0;

	fbpa_result_t       expected_results [$];
	logic [RING_AW-1:0] held_blocks [$];
	int                 send_idle_pct  = 25;
	int                 recv_idle_pct  = 88;
	int                 mismatch_count = 0;
	int                 stall_cycles   = 0;

	function automatic void push_free(logic [RING_AW-1:0] blk);
		ring_q[tail_q] = blk;
		tail_q = tail_q + 1'b1;
		flag_free[blk] = 1'b1;
		free_n++;
	endfunction

	// result of one request, advancing the shadow state
	function automatic fbpa_result_t pool_predict(logic [1:0] mode, logic [SIZE_W-1:0] req,
			logic [RING_AW-1:0] idx);
		fbpa_result_t r;
		int unsigned  goal;
		r = '0;
		case (mode)
			MODE_ALLOC: begin
				if (req > size_limit) begin
					r.status = STAT_TOO_LARGE;
				end else begin
					if (req > largest_n)
						largest_n = req;
					if (free_n == 0) begin
						if (fail_n != '1)
							fail_n = fail_n + 1'b1;
						r.status = STAT_EMPTY;
					end else begin
						r.granted_index = ring_q[head_q];
						head_q = head_q + 1'b1;
						free_n--;
						flag_free[r.granted_index] = 1'b0;
						r.granted = 1'b1;
						used_n++;
						if (used_n > peak_n)
							peak_n = used_n;
					end
				end
			end
			MODE_FREE: begin
				if (idx >= segs_n * BLOCKS_PER_SEG) begin
					r.status = STAT_BAD_INDEX;
				end else if (flag_free[idx]) begin
					r.status = STAT_ALREADY_FREE;
				end else begin
					push_free(idx);
					if (used_n > 0)
						used_n--;
				end
			end
			MODE_GROW: begin
				// capped by segment limit and by what fits in the ring
				goal = seg_goal;
				if (goal > SEG_LIMIT)
					goal = SEG_LIMIT;
				if (goal > RING_DEPTH / BLOCKS_PER_SEG)
					goal = RING_DEPTH / BLOCKS_PER_SEG;
				while (segs_n < goal) begin
					for (int i = 0; i < BLOCKS_PER_SEG; i++)
						push_free(RING_AW'(segs_n * BLOCKS_PER_SEG + i));
					segs_n++;
				end
			end
			default: ;
		endcase
		r.in_use_count    = CNT_W'(used_n);
		r.free_count      = CNT_W'(free_n);
		r.total_count     = CNT_W'(segs_n * BLOCKS_PER_SEG);
		r.peak_in_use     = CNT_W'(peak_n);
		r.largest_request = largest_n;
		r.failure_total   = fail_n;
		return r;
	endfunction

	function automatic void note_mismatch(string what, logic [FAIL_W-1:0] want,
			logic [FAIL_W-1:0] got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("tb: mismatch on %s: expected %0h, got %0h", what, want, got);
	endfunction

	function automatic void check_field(string what, logic [FAIL_W-1:0] want,
			logic [FAIL_W-1:0] got);
		if (got !== want)
			note_mismatch(what, want, got);
	endfunction

	// drive one request beat at the falling edge, predict when it is taken
	task automatic send_request(logic [1:0] mode, logic [SIZE_W-1:0] req,
			logic [RING_AW-1:0] idx, logic typed, logic granted,
			logic [RING_AW-1:0] gidx, logic [2:0] status);
		fbpa_result_t res;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {2'b00, idx, req, mode};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		res = pool_predict(mode, req, idx);
		if (typed) begin
			res.granted       = granted;
			res.granted_index = gidx;
			res.status        = status;
		end
		if (res.granted)
			held_blocks.push_back(res.granted_index);
		expected_results.push_back(res);
	endtask

	// stop sending until every pending result has come back
	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] which, logic [SIZE_W-1:0] value);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = which;
		cfg_wdata = value;
		@(posedge clk);
		if (which == CFG_BLOCK_SIZE)
			size_limit = value;
		else
			seg_goal = 32'(value[SEG_W-1:0]);
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// mostly allocate and free of held blocks, plus noise
	task automatic run_random(int count);
		int                 pick;
		int                 pos;
		logic [1:0]         mode;
		logic [SIZE_W-1:0]  req;
		logic [RING_AW-1:0] idx;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			req  = SIZE_W'($urandom);
			idx  = RING_AW'($urandom);
			if (pick < 45) begin
				mode = MODE_ALLOC;
				case ($urandom_range(9))
					0: req = size_limit;
					1: req = size_limit + 1'b1;
					2: req = SIZE_W'($urandom);
					default: req = SIZE_W'($urandom_range(size_limit, 0));
				endcase
			end else if (pick < 80) begin
				mode = MODE_FREE;
				if (held_blocks.size() != 0) begin
					pos = $urandom_range(held_blocks.size() - 1);
					idx = held_blocks[pos];
					held_blocks.delete(pos);
				end
			end else if (pick < 92) begin
				mode = MODE_FREE;
			end else if (pick < 96) begin
				mode = MODE_GROW;
			end else begin
				mode = MODE_NONE;
			end
			send_request(mode, req, idx, 1'b0, 1'b0, '0, STAT_OK);
			if ($urandom_range(199) == 0)
				drain_results();
		end
	endtask

	// receiver back-pressure
	always @(negedge clk)
		m_axis_tready = ($urandom_range(99) >= recv_idle_pct);

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin
		fbpa_result_t got;
		fbpa_result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (expected_results.size() == 0) begin
				note_mismatch("unrequested result beat", '0, FAIL_W'(got.status));
			end else begin
				want = expected_results.pop_front();
				check_field("granted", FAIL_W'(want.granted), FAIL_W'(got.granted));
				check_field("granted_index", FAIL_W'(want.granted_index),
					FAIL_W'(got.granted_index));
				check_field("status", FAIL_W'(want.status), FAIL_W'(got.status));
				check_field("in_use_count", FAIL_W'(want.in_use_count),
					FAIL_W'(got.in_use_count));
				check_field("free_count", FAIL_W'(want.free_count),
					FAIL_W'(got.free_count));
				check_field("total_count", FAIL_W'(want.total_count),
					FAIL_W'(got.total_count));
				check_field("peak_in_use", FAIL_W'(want.peak_in_use),
					FAIL_W'(got.peak_in_use));
				check_field("largest_request", FAIL_W'(want.largest_request),
					FAIL_W'(got.largest_request));
				check_field("failure_total", want.failure_total, got.failure_total);
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows
		for (int i = 0; i < PLAN_LEN; i++) begin
			if (plan[i].kind == ROW_REG) begin
				drain_results();
				write_reg(plan[i].idx[CFG_IDX_W-1:0], plan[i].req);
			end else begin
				send_request(plan[i].mode, plan[i].req, plan[i].idx, plan[i].typed,
					plan[i].granted, plan[i].gidx, plan[i].status);
			end
		end

		// random legs: idling setting, block size and segment goal per leg
		for (int leg = 0; leg < LEG_COUNT; leg++) begin
			drain_results();
			send_idle_pct = (leg < 2) ? 25 : (leg < 4) ? 88 : 0;
			recv_idle_pct = (leg < 2) ? 88 : (leg < 4) ? 25 : 0;
			case (leg)
				0: write_reg(CFG_BLOCK_SIZE, 16'd4);
				3: write_reg(CFG_BLOCK_SIZE, 16'd65532);
				default: write_reg(CFG_BLOCK_SIZE, SIZE_W'(4 * $urandom_range(16383, 1)));
			endcase
			write_reg(CFG_TARGET_SEGS, SIZE_W'(LEG_GOAL[leg]));
			run_random(LEG_ITEMS);
		end

		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
